### src/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared types and constants of the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// hue + bias lands in 352..65887 for any 16-bit signed hue (bias = 92 * 360)
	localparam logic [16:0] HUE_BIAS   = 17'd33120;
	// ceil(2^24 / 360): exact quotient for any biased hue
	localparam logic [15:0] RECIP_360  = 16'd46604;
	localparam int          RECIP_360_SHIFT = 24;
	localparam logic [15:0] DEG_360    = 16'd360;
	// ceil(2^20 / 60): exact quotient for dividends below 2^14
	localparam logic [14:0] RECIP_60   = 15'd17477;
	localparam int          RECIP_60_SHIFT = 20;
	localparam logic [5:0]  DEG_60     = 6'd60;
	localparam logic [14:0] UNIT_X60   = 15'd15360;
	localparam logic [9:0]  UNIT       = 10'd256;

	localparam logic [2:0] SEC_0 = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;

	typedef struct packed {
		logic [2:0] sector;
		logic [5:0] rem;
		logic [8:0] sat;
		logic [8:0] val;
	} sec_t;

endpackage

### src/hsv2rgb_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb channel interfaces
// hsv input word and rgb output word, valid/ready handshake
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] hue_degrees;
	logic signed [9:0]  saturation;
	logic signed [9:0]  brightness;

	modport source (output valid, output hue_degrees, output saturation,
		output brightness, input ready);
	modport sink (input valid, input hue_degrees, input saturation,
		input brightness, output ready);
endinterface

interface hsv2rgb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### src/hsv2rgb_wrap.sv
// ----------------------------------------------------------------------------
// hsv2rgb_wrap
// stages 1-4: clamp s/v, wrap hue into 0..359, split into sector and remainder
// ----------------------------------------------------------------------------
module hsv2rgb_wrap (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  hue_degrees,
	input  logic signed [9:0]   saturation,
	input  logic signed [9:0]   brightness,
	output logic                out_valid,
	input  logic                out_ready,
	output hsv2rgb_pkg::sec_t   out_data
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        en1, en2, en3, en4;
	logic [16:0] u_s1, u_s2;
	logic [7:0]  quo_s2;
	logic [8:0]  wrapped_s3;
	logic [8:0]  sat_s1, sat_s2, sat_s3;
	logic [8:0]  val_s1, val_s2, val_s3;
	hsv2rgb_pkg::sec_t sec_s4;

	logic [16:0] biased;
	logic [8:0]  sat_c, val_c;
	logic [32:0] quo_prod;
	logic [16:0] quo_x360;
	logic [16:0] wrap_diff;
	logic [2:0]  sector_c;
	logic [8:0]  base_c;
	logic [8:0]  rem_c;

	// a stage takes a new word when it is empty or its content moves on
	assign en4 = !valid_s4 || out_ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_ready = en1;

	assign biased = {hue_degrees[15], hue_degrees} + hsv2rgb_pkg::HUE_BIAS;

	always_comb begin
		if (saturation[9]) begin
			sat_c = 9'd0;
		end else if (saturation > $signed(hsv2rgb_pkg::UNIT)) begin
			sat_c = hsv2rgb_pkg::UNIT[8:0];
		end else begin
			sat_c = saturation[8:0];
		end
		if (brightness[9]) begin
			val_c = 9'd0;
		end else if (brightness > $signed(hsv2rgb_pkg::UNIT)) begin
			val_c = hsv2rgb_pkg::UNIT[8:0];
		end else begin
			val_c = brightness[8:0];
		end
	end

	assign quo_prod  = 33'(u_s1) * 33'(hsv2rgb_pkg::RECIP_360);
	assign quo_x360  = 17'(17'(quo_s2) * hsv2rgb_pkg::DEG_360);
	assign wrap_diff = u_s2 - quo_x360;

	always_comb begin
		if (wrapped_s3 >= 9'd300) begin
			sector_c = hsv2rgb_pkg::SEC_5;
			base_c   = 9'd300;
		end else if (wrapped_s3 >= 9'd240) begin
			sector_c = hsv2rgb_pkg::SEC_4;
			base_c   = 9'd240;
		end else if (wrapped_s3 >= 9'd180) begin
			sector_c = hsv2rgb_pkg::SEC_3;
			base_c   = 9'd180;
		end else if (wrapped_s3 >= 9'd120) begin
			sector_c = hsv2rgb_pkg::SEC_2;
			base_c   = 9'd120;
		end else if (wrapped_s3 >= 9'd60) begin
			sector_c = hsv2rgb_pkg::SEC_1;
			base_c   = 9'd60;
		end else begin
			sector_c = hsv2rgb_pkg::SEC_0;
			base_c   = 9'd0;
		end
		rem_c = wrapped_s3 - base_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			u_s1   <= biased;
			sat_s1 <= sat_c;
			val_s1 <= val_c;
		end
		if (en2) begin
			u_s2   <= u_s1;
			quo_s2 <= quo_prod[hsv2rgb_pkg::RECIP_360_SHIFT +: 8];
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
		end
		if (en3) begin
			wrapped_s3 <= wrap_diff[8:0];
			sat_s3     <= sat_s2;
			val_s3     <= val_s2;
		end
		if (en4) begin
			sec_s4.sector <= sector_c;
			sec_s4.rem    <= rem_c[5:0];
			sec_s4.sat    <= sat_s3;
			sec_s4.val    <= val_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = sec_s4;

endmodule

### src/hsv2rgb_level.sv
// ----------------------------------------------------------------------------
// hsv2rgb_level
// stages 5-7: p/q/t levels, scale by 255*v, divide out and order the channels
// ----------------------------------------------------------------------------
module hsv2rgb_level (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hsv2rgb_pkg::sec_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue
);

	logic        valid_s5, valid_s6, valid_s7;
	logic        en5, en6, en7;
	logic [2:0]  sector_s5, sector_s6;
	logic [15:0] vv_s5;
	logic [13:0] nq_s5, nt_s5;
	logic [8:0]  np_s5;
	logic [13:0] xq_s6, xt_s6;
	logic [7:0]  cv_s6, cp_s6;
	logic [7:0]  red_s7, green_s7, blue_s7;

	logic [14:0] sr_c, srt_c;
	logic [5:0]  rt_c;
	logic [16:0] vv_c;
	logic [29:0] mq_c, mt_c;
	logic [24:0] mp_c;
	logic [28:0] dq_c, dt_c;
	logic [7:0]  cq_c, ct_c;

	assign en7 = !valid_s7 || out_ready;
	assign en6 = !valid_s6 || en7;
	assign en5 = !valid_s5 || en6;
	assign in_ready = en5;

	// s*r and s*(60-r) never exceed 256*60
	assign rt_c  = hsv2rgb_pkg::DEG_60 - in_data.rem;
	assign sr_c  = 15'(in_data.sat) * 15'(in_data.rem);
	assign srt_c = 15'(in_data.sat) * 15'(rt_c);
	assign vv_c  = 17'({in_data.val, 8'b0}) - 17'(in_data.val);

	assign mq_c = 30'(vv_s5) * 30'(nq_s5);
	assign mt_c = 30'(vv_s5) * 30'(nt_s5);
	assign mp_c = 25'(vv_s5) * 25'(np_s5);

	// divide by 60 after the shift by 16 already taken
	assign dq_c = 29'(xq_s6) * 29'(hsv2rgb_pkg::RECIP_60);
	assign dt_c = 29'(xt_s6) * 29'(hsv2rgb_pkg::RECIP_60);
	assign cq_c = dq_c[hsv2rgb_pkg::RECIP_60_SHIFT +: 8];
	assign ct_c = dt_c[hsv2rgb_pkg::RECIP_60_SHIFT +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en5) valid_s5 <= in_valid;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			sector_s5 <= in_data.sector;
			vv_s5     <= vv_c[15:0];
			nq_s5     <= 14'(hsv2rgb_pkg::UNIT_X60 - sr_c);
			nt_s5     <= 14'(hsv2rgb_pkg::UNIT_X60 - srt_c);
			np_s5     <= 9'(hsv2rgb_pkg::UNIT - 10'(in_data.sat));
		end
		if (en6) begin
			sector_s6 <= sector_s5;
			xq_s6     <= mq_c[29:16];
			xt_s6     <= mt_c[29:16];
			cp_s6     <= mp_c[23:16];
			cv_s6     <= vv_s5[15:8];
		end
		if (en7) begin
			case (sector_s6)
				hsv2rgb_pkg::SEC_1: begin
					red_s7 <= cq_c;  green_s7 <= cv_s6; blue_s7 <= cp_s6;
				end
				hsv2rgb_pkg::SEC_2: begin
					red_s7 <= cp_s6; green_s7 <= cv_s6; blue_s7 <= ct_c;
				end
				hsv2rgb_pkg::SEC_3: begin
					red_s7 <= cp_s6; green_s7 <= cq_c;  blue_s7 <= cv_s6;
				end
				hsv2rgb_pkg::SEC_4: begin
					red_s7 <= ct_c;  green_s7 <= cp_s6; blue_s7 <= cv_s6;
				end
				hsv2rgb_pkg::SEC_5: begin
					red_s7 <= cv_s6; green_s7 <= cp_s6; blue_s7 <= cq_c;
				end
				default: begin
					red_s7 <= cv_s6; green_s7 <= ct_c;  blue_s7 <= cp_s6;
				end
			endcase
		end
	end

	assign out_valid = valid_s7;
	assign red       = red_s7;
	assign green     = green_s7;
	assign blue      = blue_s7;

endmodule

### src/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// hsv triple in, 8-bit rgb word out, seven-stage pipeline
// ----------------------------------------------------------------------------
// Takes one hsv word per clock unless back-pressure holds the pipe, and
// returns one rgb word per word in, in order. A word passes through the
// seven pipeline registers: hue bias and s/v clamp, divide by 360 via a
// reciprocal multiply, remainder, sector split, p/q/t levels, scaling by
// 255*v, and the final divide by 60 with channel ordering. Each stage holds
// its word under back-pressure and takes a new one when it is empty, so
// bubbles are squeezed out and hsv.ready stays high while any stage is free.
module hsv_to_rgb_converter (
	input  logic                 clk,
	input  logic                 arst_n,
	hsv2rgb_in_if.sink           hsv,
	hsv2rgb_out_if.source        rgb
);

	logic              mid_valid;
	logic              mid_ready;
	hsv2rgb_pkg::sec_t mid_data;

	hsv2rgb_wrap u_wrap (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (hsv.valid),
		.in_ready    (hsv.ready),
		.hue_degrees (hsv.hue_degrees),
		.saturation  (hsv.saturation),
		.brightness  (hsv.brightness),
		.out_valid   (mid_valid),
		.out_ready   (mid_ready),
		.out_data    (mid_data)
	);

	hsv2rgb_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (rgb.valid),
		.out_ready (rgb.ready),
		.red       (rgb.red),
		.green     (rgb.green),
		.blue      (rgb.blue)
	);

	// an empty output stage must open the whole ready chain
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb.valid |-> hsv.ready)
		else $error("input not ready with empty output stage");

	// a word between the two halves is not dropped while stalled
	a_mid_held: assert property (@(posedge clk) disable iff (!arst_n)
		mid_valid && !mid_ready |=> mid_valid && $stable(mid_data))
		else $error("stalled word between halves lost");

	// sector, remainder, saturation and brightness stay in range
	a_mid_range: assert property (@(posedge clk) disable iff (!arst_n)
		mid_valid |-> (mid_data.sector <= hsv2rgb_pkg::SEC_5) &&
			(mid_data.rem < hsv2rgb_pkg::DEG_60) &&
			(mid_data.sat <= hsv2rgb_pkg::UNIT[8:0]) &&
			(mid_data.val <= hsv2rgb_pkg::UNIT[8:0]))
		else $error("sector split out of range");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter testbench
// drives hsv words through the converter in random bursts, stalls the rgb
// side on a changing pattern, and checks every rgb word against a predictor
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 1900;

	typedef struct {
		logic signed [15:0] hue;
		logic signed [9:0]  sat;
		logic signed [9:0]  val;
	} hsv_word_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hsv2rgb_in_if  hsv ();
	hsv2rgb_out_if rgb ();

	hsv_to_rgb_converter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv.sink),
		.rgb    (rgb.source)
	);

	hsv_word_t pending_hsv[$];
	rgb_word_t expected_rgb[$];
	int        mismatch_count = 0;
	int        cycle_count = 0;

	always #5 clk = ~clk;

	initial begin
		hsv.valid = 1'b0;
		hsv.hue_degrees = '0;
		hsv.saturation = '0;
		hsv.brightness = '0;
		rgb.ready = 1'b0;
	end

	function automatic logic [8:0] clamp_level(logic signed [9:0] x);
		if (x < 0)
			return 9'd0;
		if (x > 256)
			return 9'd256;
		return x[8:0];
	endfunction

	// exact rational levels, one truncation per channel
	function automatic rgb_word_t hsv_to_rgb_color(hsv_word_t w);
		int                h;
		int unsigned       s;
		longint unsigned   v;
		logic [2:0]        sector;
		int unsigned       r;
		longint unsigned   cv, cp, cq, ct;
		rgb_word_t         c;
		h = int'(w.hue) % 360;
		if (h < 0)
			h += 360;
		s = clamp_level(w.sat);
		v = clamp_level(w.val);
		sector = 3'(h / 60);
		r = h % 60;
		cv = (64'd255 * v) / 64'd256;
		cp = (64'd255 * v * longint'(256 - s)) / 64'd65536;
		cq = (64'd255 * v * longint'(15360 - s * r)) / 64'd3932160;
		ct = (64'd255 * v * longint'(15360 - s * (60 - r))) / 64'd3932160;
		case (sector)
			hsv2rgb_pkg::SEC_1: begin
				c.red = cq[7:0]; c.green = cv[7:0]; c.blue = cp[7:0];
			end
			hsv2rgb_pkg::SEC_2: begin
				c.red = cp[7:0]; c.green = cv[7:0]; c.blue = ct[7:0];
			end
			hsv2rgb_pkg::SEC_3: begin
				c.red = cp[7:0]; c.green = cq[7:0]; c.blue = cv[7:0];
			end
			hsv2rgb_pkg::SEC_4: begin
				c.red = ct[7:0]; c.green = cp[7:0]; c.blue = cv[7:0];
			end
			hsv2rgb_pkg::SEC_5: begin
				c.red = cv[7:0]; c.green = cp[7:0]; c.blue = cq[7:0];
			end
			default: begin
				c.red = cv[7:0]; c.green = ct[7:0]; c.blue = cp[7:0];
			end
		endcase
		return c;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] rgb check: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic queue_hsv(int hue, int sat, int val);
		hsv_word_t w;
		w.hue = 16'(hue);
		w.sat = 10'(sat);
		w.val = 10'(val);
		pending_hsv.push_back(w);
	endtask

	task automatic wait_idle();
		while (pending_hsv.size() != 0 || hsv.valid || expected_rgb.size() != 0)
			@(posedge clk);
	endtask

	// hsv driver: bursts of words separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : drive_hsv
		hsv_word_t w;
		hsv_word_t sent;
		if (!arst_n) begin
			hsv.valid <= 1'b0;
			hsv.hue_degrees <= '0;
			hsv.saturation <= '0;
			hsv.brightness <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (hsv.valid && hsv.ready) begin
				sent.hue = hsv.hue_degrees;
				sent.sat = hsv.saturation;
				sent.val = hsv.brightness;
				expected_rgb.push_back(hsv_to_rgb_color(sent));
			end
			if (!hsv.valid || hsv.ready) begin
				if (gap_left > 0) begin
					hsv.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_hsv.size() != 0) begin
					w = pending_hsv.pop_front();
					hsv.valid <= 1'b1;
					hsv.hue_degrees <= w.hue;
					hsv.saturation <= w.sat;
					hsv.brightness <= w.val;
					if (burst_left <= 1) begin
						// long bursts with no gap now and then
						burst_left <= ($urandom_range(0, 3) == 0) ?
							$urandom_range(60, 200) : $urandom_range(1, 12);
						case ($urandom_range(0, 3))
							0: gap_left <= 0;
							1: gap_left <= 1;
							2: gap_left <= $urandom_range(1, 6);
							default: gap_left <= $urandom_range(2, 20);
						endcase
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					hsv.valid <= 1'b0;
				end
			end
		end
	end

	// rgb monitor: ready follows a 16-bit stall mask that changes every lap
	logic [15:0] ready_mask = 16'hffff;
	logic [3:0]  ready_idx = '0;

	always @(posedge clk or negedge arst_n) begin : watch_rgb
		rgb_word_t want;
		if (!arst_n) begin
			rgb.ready <= 1'b0;
			ready_mask <= 16'hffff;
			ready_idx <= '0;
		end else begin
			if (rgb.valid && rgb.ready) begin
				if (expected_rgb.size() == 0) begin
					report_mismatch($sformatf("unexpected word r=%0d g=%0d b=%0d",
						rgb.red, rgb.green, rgb.blue));
				end else begin
					want = expected_rgb.pop_front();
					if (rgb.red !== want.red)
						report_mismatch($sformatf("red got %0d want %0d",
							rgb.red, want.red));
					if (rgb.green !== want.green)
						report_mismatch($sformatf("green got %0d want %0d",
							rgb.green, want.green));
					if (rgb.blue !== want.blue)
						report_mismatch($sformatf("blue got %0d want %0d",
							rgb.blue, want.blue));
				end
			end
			ready_idx <= ready_idx + 4'd1;
			if (ready_idx == 4'd15) begin
				case ($urandom_range(0, 3))
					0: ready_mask <= 16'hffff;
					1: ready_mask <= 16'($urandom) | 16'h0001;
					2: ready_mask <= 16'($urandom | $urandom) | 16'h0001;
					default: ready_mask <= 16'($urandom & $urandom) | 16'h0001;
				endcase
			end
			rgb.ready <= ready_mask[ready_idx];
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int hue, sat, val;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// one word per sector, wrap points, clamp edges, grey
		queue_hsv(0, 256, 256);
		queue_hsv(60, 256, 256);
		queue_hsv(120, 256, 200);
		queue_hsv(180, 128, 256);
		queue_hsv(240, 256, 256);
		queue_hsv(300, 255, 255);
		queue_hsv(359, 256, 256);
		queue_hsv(360, 256, 256);
		queue_hsv(-1, 256, 256);
		queue_hsv(-360, 200, 200);
		queue_hsv(-32768, 511, 511);
		queue_hsv(32767, -512, -512);
		queue_hsv(30, 0, 256);
		queue_hsv(90, -1, 300);
		queue_hsv(150, 257, 257);
		queue_hsv(210, 511, -1);
		queue_hsv(270, -512, 511);
		queue_hsv(330, 100, 0);
		queue_hsv(45, 256, 1);
		queue_hsv(-32767, 37, 129);
		queue_hsv(1, 256, 256);
		queue_hsv(59, 256, 256);
		wait_idle();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			case ($urandom_range(0, 3))
				0: hue = $urandom_range(0, 359);
				1: hue = $urandom_range(0, 4) * 360 - $urandom_range(0, 1) * 720
					+ $urandom_range(0, 2) - 1;
				default: hue = int'(16'($urandom)) - 32768;
			endcase
			case ($urandom_range(0, 3))
				0: sat = int'(10'($urandom)) - 512;
				1: sat = ($urandom_range(0, 1) != 0) ? 256 : 0;
				default: sat = $urandom_range(0, 256);
			endcase
			case ($urandom_range(0, 3))
				0: val = int'(10'($urandom)) - 512;
				1: val = ($urandom_range(0, 1) != 0) ? 256 : 255;
				default: val = $urandom_range(0, 256);
			endcase
			queue_hsv(hue, sat, val);
			// hold the sender once midway until the pipe has emptied
			if (i == RANDOM_WORDS / 2)
				wait_idle();
		end
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_rgb.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### hsv_to_rgb_converter.f
src/hsv2rgb_pkg.sv
src/hsv2rgb_if.sv
src/hsv2rgb_wrap.sv
src/hsv2rgb_level.sv
src/hsv_to_rgb_converter.sv
verif/testbench.sv
